// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the calendar datapath; gdbd_queue includes them.
// Needs no other file; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/gdbd_pkg.sv =====
// Shared types, constants and calendar tables for the days-between-dates block.
// No dependencies; every other module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package gdbd_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 23;
	localparam int DNUM_W  = 23;

	// floor(x / 100) == (x * RECIP100) >> RECIP_SHIFT for every 14-bit x.
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam int RECIP_SHIFT = 19;
	localparam int QUO_W       = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP100 = 13'd5243;

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 23'd4194303;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic                 valid;
		logic [DAY_W-1:0]     d1;
		logic [MONTH_W-1:0]   m1;
		logic [YEAR_W-1:0]    y1;
		logic                 leap1;
		logic [DAY_W-1:0]     d2;
		logic [MONTH_W-1:0]   m2;
		logic [YEAR_W-1:0]    y2;
		logic                 leap2;
	} gdbd_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} gdbd_qstat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_CHK,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_M365,
		B_M100,
		B_SUM,
		B_DIFF
	} back_state_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in all months ahead of month m in a common year.
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gregorian_days_between_dates.sv =====
// Top level of the days-between-dates block: front end, queue and back end.
// Depends on gdbd_pkg, gdbd_front, gdbd_queue and gdbd_back.
//
//   channel | dir | tdata                                   | tuser
//   s_*     | in  | first d/m/y, second d/m/y (48 bits)     | -
//   m_*     | out | day_count, 23-bit signed (24 bits)      | dates_valid
//
// The front end takes a request when idle and checks both dates one after the other,
// sharing one reciprocal multiplier between them for the century test.
// The back end steps through B_M365, B_M100 and B_SUM per date to form day
// numbers (one constant multiply each for 365 and for the century count) and
// then the difference in B_DIFF; items with valid dates set the sustained rate.
// Items with invalid dates skip the day numbers and go straight to B_DIFF.
// A two-entry queue lets the front end keep checking while the back end or the
// result register is stalled; reset clears all control state at once.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_days_between_dates #(
	parameter int unsigned MAX_YEAR = gdbd_pkg::MAX_YEAR_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// first_day[4:0], first_month[8:5], first_year[22:9],
	// second_day[27:23], second_month[31:28], second_year[45:32], zero fill
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// day_count[22:0], zero fill
	output logic [23:0]      m_tdata,
	// dates_valid[0]
	output logic [0:0]       m_tuser
);
	import gdbd_pkg::*;

	gdbd_qstat_t qstat;
	gdbd_item_t  push_item, pop_item;
	logic push, pop;

	gdbd_front #(
		.MAX_YEAR (MAX_YEAR)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	gdbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	gdbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/core/gdbd_front.sv =====
// Front end: takes a request, finds leap years and checks both dates.
// Depends on gdbd_pkg; feeds gdbd_queue.
`timescale 1ns / 1ps
`default_nettype none

module gdbd_front #(
	parameter int unsigned MAX_YEAR = gdbd_pkg::MAX_YEAR_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// first_day, first_month, first_year, second_day, second_month, second_year
	input  wire logic [47:0]         s_tdata,
	input  wire gdbd_pkg::gdbd_qstat_t qstat,
	output logic                     push,
	output gdbd_pkg::gdbd_item_t     push_item
);
	import gdbd_pkg::*;

	localparam logic [15:0] YEAR_LIMIT = 16'(MAX_YEAR);

	front_state_t state_q, state_nxt;
	logic sel_q;
	logic [DAY_W-1:0]   d1_q, d2_q;
	logic [MONTH_W-1:0] m1_q, m2_q;
	logic [YEAR_W-1:0]  y1_q, y2_q;
	logic ok1_q, leap1_q, ok2_q, leap2_q;
	logic [PROD_W-1:0] prod_q;

	logic accept;
	logic [DAY_W-1:0]   d_sel;
	logic [MONTH_W-1:0] m_sel;
	logic [YEAR_W-1:0]  y_sel;
	logic [QUO_W-1:0]   quo;
	logic [YEAR_W-1:0]  rem;
	logic leap_c, ok_c;

	assign accept = s_tvalid && s_tready;

	assign d_sel = sel_q ? d2_q : d1_q;
	assign m_sel = sel_q ? m2_q : m1_q;
	assign y_sel = sel_q ? y2_q : y1_q;

	assign quo = prod_q[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		rem    = y_sel - YEAR_W'({6'd0, quo} * 14'd100);
		// Divisible by 4, and a century only when the century count is divisible by 4.
		leap_c = (y_sel[1:0] == 2'b00) && ((rem != '0) || (quo[1:0] == 2'b00));
		ok_c   = (y_sel != '0) && ({2'b00, y_sel} <= YEAR_LIMIT)
			&& (m_sel >= MON_JAN) && (m_sel <= MON_DEC)
			&& (d_sel != '0) && (d_sel <= month_len(m_sel, leap_c));
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_nxt = F_MUL;
			F_MUL:  state_nxt = F_CHK;
			F_CHK:  state_nxt = sel_q ? F_PUSH : F_MUL;
			F_PUSH: if (!qstat.full) state_nxt = F_IDLE;
			default: state_nxt = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == F_IDLE);
		push     = (state_q == F_PUSH) && !qstat.full;
	end

	always_comb begin
		push_item.valid = ok1_q && ok2_q && (y2_q >= y1_q);
		push_item.d1    = d1_q;
		push_item.m1    = m1_q;
		push_item.y1    = y1_q;
		push_item.leap1 = leap1_q;
		push_item.d2    = d2_q;
		push_item.m2    = m2_q;
		push_item.y2    = y2_q;
		push_item.leap2 = leap2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				sel_q <= 1'b0;
			end else if (state_q == F_CHK) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d1_q <= s_tdata[4:0];
			m1_q <= s_tdata[8:5];
			y1_q <= s_tdata[22:9];
			d2_q <= s_tdata[27:23];
			m2_q <= s_tdata[31:28];
			y2_q <= s_tdata[45:32];
		end
		if (state_q == F_MUL) begin
			prod_q <= {RECIP_W'(0), y_sel} * {YEAR_W'(0), RECIP100};
		end
		if (state_q == F_CHK) begin
			if (sel_q) begin
				ok2_q   <= ok_c;
				leap2_q <= leap_c;
			end else begin
				ok1_q   <= ok_c;
				leap1_q <= leap_c;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gdbd_queue.sv =====
// Short queue between the checking front end and the day-count back end.
// Depends on gdbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gdbd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire gdbd_pkg::gdbd_item_t push_item,
	input  wire logic              pop,
	output gdbd_pkg::gdbd_item_t   pop_item,
	output gdbd_pkg::gdbd_qstat_t  qstat
);
	import gdbd_pkg::*;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	gdbd_item_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = (cnt_q == CNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && qstat.full, "push into a full queue")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && qstat.empty, "pop from an empty queue")
	`ASSERT_CLK(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(QDEPTH), "queue count out of range")
	`ASSERT_CLK(a_cnt_up, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "count did not rise on push")

endmodule

`default_nettype wire

// ===== rtl/core/gdbd_back.sv =====
// Back end: turns both checked dates into day numbers and forms the difference.
// Depends on gdbd_pkg; drains gdbd_queue and owns the result register.
`timescale 1ns / 1ps
`default_nettype none

module gdbd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gdbd_pkg::gdbd_qstat_t qstat,
	input  wire gdbd_pkg::gdbd_item_t  pop_item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// day_count
	output logic [23:0]            m_tdata,
	// dates_valid
	output logic [0:0]             m_tuser
);
	import gdbd_pkg::*;

	back_state_t state_q, state_nxt;
	gdbd_item_t item_q;
	logic sel_q;
	logic [DNUM_W-1:0] acc_q, dn1_q, dn2_q;
	logic [PROD_W-1:0] prod_q;
	logic m_tvalid_q;
	logic [COUNT_W-1:0] count_q;
	logic valid_q;

	logic out_load;
	logic [DAY_W-1:0]   d_sel;
	logic [MONTH_W-1:0] m_sel;
	logic [YEAR_W-1:0]  p_sel;
	logic leap_sel;
	logic [QUO_W-1:0] quo;
	logic [DNUM_W-1:0] dnum;
	logic signed [DNUM_W:0] diff;
	logic [COUNT_W-1:0] count_c;

	assign d_sel    = sel_q ? item_q.d2 : item_q.d1;
	assign m_sel    = sel_q ? item_q.m2 : item_q.m1;
	assign p_sel    = (sel_q ? item_q.y2 : item_q.y1) - 1'b1;
	assign leap_sel = sel_q ? item_q.leap2 : item_q.leap1;
	assign quo      = prod_q[PROD_W-1:RECIP_SHIFT];

	// Days before Jan 1 of this year come from 365*(y-1) plus the leap days before it.
	always_comb begin
		dnum = acc_q + DNUM_W'(p_sel >> 2) - DNUM_W'(quo) + DNUM_W'(quo >> 2)
			+ DNUM_W'(days_before(m_sel)) + DNUM_W'(d_sel)
			+ DNUM_W'((m_sel > MON_FEB) && leap_sel);
	end

	always_comb begin
		diff = $signed({1'b0, dn2_q}) - $signed({1'b0, dn1_q});
		if (!item_q.valid) begin
			count_c = '0;
		end else if (diff > $signed({1'b0, COUNT_MAX})) begin
			count_c = COUNT_MAX;
		end else begin
			count_c = diff[COUNT_W-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE: if (!qstat.empty) state_nxt = pop_item.valid ? B_M365 : B_DIFF;
			B_M365: state_nxt = B_M100;
			B_M100: state_nxt = B_SUM;
			B_SUM:  state_nxt = sel_q ? B_DIFF : B_M365;
			B_DIFF: if (out_load) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == B_IDLE) && !qstat.empty;
		out_load = (state_q == B_DIFF) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			sel_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop) begin
				sel_q <= 1'b0;
			end else if (state_q == B_SUM) begin
				sel_q <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_item;
		end
		if (state_q == B_M365) begin
			acc_q <= {9'd0, p_sel} * {14'd0, DAYS_PER_YEAR};
		end
		if (state_q == B_M100) begin
			prod_q <= {RECIP_W'(0), p_sel} * {YEAR_W'(0), RECIP100};
		end
		if (state_q == B_SUM) begin
			if (sel_q) begin
				dn2_q <= dnum;
			end else begin
				dn1_q <= dnum;
			end
		end
		if (out_load) begin
			count_q <= count_c;
			valid_q <= item_q.valid;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {1'b0, count_q};
	assign m_tuser[0] = valid_q;

endmodule

`default_nettype wire
